// ===== rtl/nfbl_pkg.sv =====
// Shared types, sizes and constants for the nibble frame bitmap link.
// Used by nfbl_ctrl, nfbl_resp and the core module; nfbl_ram does not use it.
`default_nettype none

package nfbl_pkg;

  localparam int ROW_COUNT  = 16;
  localparam int ROW_AW     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int ROW_SLOTS  = 2 ** ROW_AW;
  localparam int RAM_AW     = ROW_AW + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;
  localparam int ROW_W      = 16;
  localparam int POS_W      = $clog2(4 * ROW_COUNT + 2);

  localparam logic [POS_W-1:0] DATA_POS    = POS_W'(4 * ROW_COUNT);
  localparam logic [POS_W-1:0] TRAILER_POS = POS_W'(4 * ROW_COUNT + 1);

  localparam logic [7:0] HEADER_BYTE  = 8'd1;
  localparam logic [7:0] TRAILER_BYTE = 8'd36;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0f;

  typedef enum logic [1:0] {
    CMD_RECV  = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TX_NONE    = 2'd0,
    TX_HEADER  = 2'd1,
    TX_DATA    = 2'd2,
    TX_TRAILER = 2'd3
  } tx_src_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] rx_byte;
    logic [3:0] row_index;
  } req_word_t;

  typedef struct packed {
    logic [7:0]       tx_byte;
    logic             tx_last;
    logic [ROW_W-1:0] row_data;
    logic             frame_done;
    logic             frame_ok;
  } rsp_word_t;

  // What the response stage needs to finish one word once RAM data returns
  typedef struct packed {
    tx_src_t    tx_src;
    logic [1:0] nib_sel;
    logic       row_read;
    logic       row_zero;
    logic       frame_done;
    logic       frame_ok;
  } meta_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic              re;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [ROW_AW-1:0] row_of(input logic [3:0] ri);
    logic [7:0] wide;
    wide = {4'h0, ri};
    return wide[ROW_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nfbl_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is supplied by the instantiating level.
`default_nettype none

interface nfbl_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/nfbl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone: no package dependency.
`default_nettype none

module nfbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nfbl_ctrl.sv =====
// Frame position tracking, bank selection and RAM access issue.
// Depends on nfbl_pkg.
`default_nettype none

module nfbl_ctrl
  import nfbl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire req_word_t word,
  output      ram_req_t  ram,
  output      meta_t     meta
);

  logic [POS_W-1:0]     rx_pos, rx_pos_next;
  logic [POS_W-1:0]     tx_pos, tx_pos_next;
  logic                 bank, bank_next;
  logic [ROW_SLOTS-1:0] zflag, zflag_next;
  logic [11:0]          acc, acc_next;

  logic [POS_W-1:0]  rx_k, tx_k;
  logic [ROW_AW-1:0] rx_row, tx_row, rd_row;
  logic [1:0]        rx_nib, tx_nib;
  logic [3:0]        nib_in;
  logic              commit;

  assign rx_k   = rx_pos - POS_W'(1);
  assign tx_k   = tx_pos - POS_W'(1);
  assign rx_row = rx_k[ROW_AW+1:2];
  assign tx_row = tx_k[ROW_AW+1:2];
  assign rx_nib = rx_k[1:0];
  assign tx_nib = tx_k[1:0];
  assign rd_row = row_of(word.row_index);
  assign nib_in = 4'(word.rx_byte & NIBBLE_MASK);
  assign commit = accept && meta.frame_ok;

  always_comb begin
    rx_pos_next = rx_pos;
    tx_pos_next = tx_pos;
    bank_next   = bank;
    zflag_next  = zflag;
    acc_next    = acc;

    ram.we    = 1'b0;
    ram.waddr = {~bank, rx_row};
    ram.wdata = {nib_in, acc};
    ram.re    = accept;
    ram.raddr = {bank, tx_row};

    meta.tx_src     = TX_NONE;
    meta.nib_sel    = tx_nib;
    meta.row_read   = 1'b0;
    meta.row_zero   = 1'b1;
    meta.frame_done = 1'b0;
    meta.frame_ok   = 1'b0;

    if (accept) begin
      case (word.command)
        CMD_RECV: begin
          if (rx_pos == '0) begin
            rx_pos_next = POS_W'(1);
          end else if (rx_pos <= DATA_POS) begin
            // gather three nibbles, write the whole shadow row on the fourth
            if (rx_nib == 2'd3) begin
              ram.we = 1'b1;
            end else begin
              acc_next[4*rx_nib +: 4] = nib_in;
            end
            rx_pos_next = rx_pos + POS_W'(1);
          end else begin
            meta.frame_done = 1'b1;
            if (word.rx_byte == TRAILER_BYTE) begin
              // shadow bank becomes the line store
              meta.frame_ok = 1'b1;
              bank_next     = ~bank;
              zflag_next    = '0;
            end
            rx_pos_next = '0;
          end
        end
        CMD_EMIT: begin
          if (tx_pos == '0) begin
            meta.tx_src = TX_HEADER;
            tx_pos_next = POS_W'(1);
          end else if (tx_pos <= DATA_POS) begin
            meta.tx_src   = TX_DATA;
            meta.row_zero = zflag[tx_row];
            tx_pos_next   = tx_pos + POS_W'(1);
          end else begin
            meta.tx_src = TX_TRAILER;
            tx_pos_next = '0;
          end
        end
        CMD_CLEAR: begin
          zflag_next = '1;
        end
        CMD_READ: begin
          ram.raddr     = {bank, rd_row};
          meta.row_read = 1'b1;
          meta.row_zero = zflag[rd_row] || ({3'b000, word.row_index} >= 7'(ROW_COUNT));
        end
        default: begin
          meta.row_zero = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_pos <= '0;
      tx_pos <= '0;
      bank   <= 1'b0;
      zflag  <= '1;
    end else begin
      rx_pos <= rx_pos_next;
      tx_pos <= tx_pos_next;
      bank   <= bank_next;
      zflag  <= zflag_next;
    end
    acc <= acc_next;
  end

  a_rx_pos_range: assert property (@(posedge clk) disable iff (rst)
    rx_pos <= TRAILER_POS) else $error("receive position past trailer");

  a_tx_pos_range: assert property (@(posedge clk) disable iff (rst)
    tx_pos <= TRAILER_POS) else $error("transmit position past trailer");

  a_commit_swap: assert property (@(posedge clk) disable iff (rst)
    commit |=> (bank != $past(bank)) && (zflag == '0))
    else $error("commit did not swap banks and validate rows");

  a_write_shadow: assert property (@(posedge clk) disable iff (rst)
    ram.we |-> (ram.waddr[RAM_AW-1] != bank))
    else $error("shadow write aimed at live bank");

endmodule

`default_nettype wire

// ===== rtl/nfbl_resp.sv =====
// Response stage: waits for RAM data, forms the result word, output register.
// Depends on nfbl_pkg and nfbl_stream_if.
`default_nettype none

module nfbl_resp
  import nfbl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire meta_t            meta_in,
  input  wire logic [ROW_W-1:0] rdata,
  output      logic             take,
  nfbl_stream_if.source         rsp
);

  logic      s1_valid;
  meta_t     s1_meta;
  logic      out_free;
  logic      s1_adv;
  rsp_word_t result;
  logic [3:0] nib;

  assign out_free = !rsp.valid || rsp.ready;
  assign s1_adv   = s1_valid && out_free;
  assign take     = !s1_valid || out_free;

  assign nib = 4'(rdata >> (4 * s1_meta.nib_sel));

  always_comb begin
    result            = '0;
    result.frame_done = s1_meta.frame_done;
    result.frame_ok   = s1_meta.frame_ok;
    case (s1_meta.tx_src)
      TX_HEADER:  result.tx_byte = HEADER_BYTE;
      TX_DATA:    result.tx_byte = s1_meta.row_zero ? 8'h00 : {4'h0, nib};
      TX_TRAILER: begin
        result.tx_byte = TRAILER_BYTE;
        result.tx_last = 1'b1;
      end
      default:    result.tx_byte = 8'h00;
    endcase
    if (s1_meta.row_read && !s1_meta.row_zero) begin
      result.row_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        rsp.valid <= s1_valid;
      end
    end
    if (accept) begin
      s1_meta <= meta_in;
    end
    if (out_free) begin
      rsp.data <= result;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid && $stable(s1_meta))
    else $error("stalled word lost from response stage");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (!rsp.data.frame_ok || rsp.data.frame_done))
    else $error("frame_ok without frame_done");

  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> take) else $error("word accepted with no room");

endmodule

`default_nettype wire

// ===== rtl/nibble_frame_bitmap_link_core.sv =====
// Nibble frame bitmap link: frames the stored bitmap onto a byte link and
// deframes received bytes into it. A word's metadata and RAM data register at
// acceptance; its result enters the output register when that is free. One word
// per cycle while the output is not stalled, set by the single read port of the
// row RAM issued at acceptance. Reset (synchronous rst): positions to zero, live
// bank 0, every row flagged zero; the store reads cleared at once, no clear pass.
`default_nettype none

module nibble_frame_bitmap_link_core
  import nfbl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  nfbl_stream_if.sink   req,
  nfbl_stream_if.source rsp
);

  // The RAM holds two banks of rows: one live line store and one shadow
  // buffer. A good trailer swaps banks instead of copying rows, and a clear
  // sets per-row zero flags instead of writing the RAM.

  logic             accept;
  logic             take;
  ram_req_t         ram;
  meta_t            meta;
  logic [ROW_W-1:0] rdata;

  // Take a new word whenever the response stage can move on
  assign req.ready = take;
  assign accept    = req.valid && take;

  nfbl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (req.data),
    .ram    (ram),
    .meta   (meta)
  );

  // Read only on acceptance so data holds while the output stalls
  nfbl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  nfbl_resp u_resp (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .meta_in (meta),
    .rdata   (rdata),
    .take    (take),
    .rsp     (rsp)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready) else $error("input blocked with empty output");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.data))
    else $error("stalled response word changed");

  a_trailer_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.tx_last) |-> (rsp.data.tx_byte == TRAILER_BYTE))
    else $error("last flag on a byte other than the trailer");

endmodule

`default_nettype wire
